// ----- src/rirl_pkg.sv -----
// Shared constants and types for the rank-indexed row lookup.
// Command and status codes, field widths and the packed row type.
// No dependencies.
`default_nettype none

package rirl_pkg;

	localparam int VALUE_W      = 32;
	localparam int CMD_W        = 2;
	localparam int COL_W        = 2;
	localparam int RANK_W       = 6;
	localparam int STATUS_W     = 2;
	localparam int ROW_INDEX_W  = 6;
	localparam int NUM_COLUMNS  = 3;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BADCOL = 2'd3;

	typedef struct packed {
		logic signed [VALUE_W-1:0] a;
		logic signed [VALUE_W-1:0] b;
		logic signed [VALUE_W-1:0] c;
	} row_t;

endpackage

`default_nettype wire

// ----- src/rirl_row_mem.sv -----
// Row store: one synchronous memory of rows in arrival order.
// One write port, one read port with registered read data. Uses rirl_pkg.
`default_nettype none

module rirl_row_mem #(
	parameter int MAX_ROWS = rirl_pkg::MAX_ROWS_DEF
) (
	input  wire                            clk,
	input  wire                            wr_en,
	input  wire  [$clog2(MAX_ROWS)-1:0]    wr_addr,
	input  rirl_pkg::row_t                 wr_data,
	input  wire                            rd_en,
	input  wire  [$clog2(MAX_ROWS)-1:0]    rd_addr,
	output rirl_pkg::row_t                 rd_data
);
	import rirl_pkg::*;

	row_t mem_q [MAX_ROWS];
	row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- src/rirl_order_col.sv -----
// One column's sorted order: memory of {value, arrival index} by rank,
// plus the insertion engine that walks down from the top shifting entries.
// Uses rirl_pkg.
`default_nettype none

module rirl_order_col #(
	parameter int MAX_ROWS = rirl_pkg::MAX_ROWS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  signed [rirl_pkg::VALUE_W-1:0]   new_val,
	input  wire  [$clog2(MAX_ROWS)-1:0]           new_idx,
	input  wire                                   qry_en,
	input  wire  [$clog2(MAX_ROWS)-1:0]           qry_addr,
	output logic [$clog2(MAX_ROWS)-1:0]           qry_idx,
	output logic                                  busy
);
	import rirl_pkg::*;

	localparam int IDX_W = $clog2(MAX_ROWS);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [IDX_W-1:0]          idx;
	} ord_entry_t;

	ord_entry_t mem_q [MAX_ROWS];
	ord_entry_t rd_data_q;

	logic                       busy_q;
	logic                       rd_pend_q;
	logic [IDX_W-1:0]           hole_q;
	logic signed [VALUE_W-1:0]  val_q;
	logic [IDX_W-1:0]           nidx_q;

	logic             shift;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	ord_entry_t       wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	// entry below the hole is larger: move it up into the hole
	assign shift = busy_q && rd_pend_q && (rd_data_q.value > val_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hole_q;
		wr_data = '{value: val_q, idx: nidx_q};
		rd_en   = 1'b0;
		rd_addr = qry_addr;
		if (start) begin
			rd_en   = (new_idx != '0);
			rd_addr = new_idx - IDX_W'(1);
		end else if (busy_q) begin
			wr_en = rd_pend_q || (hole_q == '0);
			if (shift) begin
				wr_data = rd_data_q;
				// speculative read of the next lower entry
				rd_en   = (hole_q != IDX_W'(1));
				rd_addr = hole_q - IDX_W'(1) - IDX_W'(1);
			end
		end else begin
			rd_en = qry_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_pend_q <= 1'b0;
		end else if (start) begin
			busy_q    <= 1'b1;
			rd_pend_q <= (new_idx != '0);
		end else if (busy_q) begin
			if (shift) begin
				rd_pend_q <= (hole_q != IDX_W'(1));
			end else begin
				busy_q    <= 1'b0;
				rd_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hole_q <= new_idx;
			val_q  <= new_val;
			nidx_q <= new_idx;
		end else if (shift) begin
			hole_q <= hole_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign qry_idx = rd_data_q.idx;
	assign busy    = busy_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("insert started while engine busy");

	a_pend_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> busy_q)
		else $error("read pending outside insertion");

	a_hole_steps_down: assert property (@(posedge clk) disable iff (!arst_n)
		shift |=> (hole_q == $past(hole_q) - IDX_W'(1)))
		else $error("hole did not move down by one");

	a_wr_rd_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("write and read hit the same entry");

endmodule

`default_nettype wire

// ----- src/rank_indexed_row_lookup.sv -----
// Channel  | handshake          | payload
// request  | in_valid/in_stall  | command, value_a..c, column_select, rank
// result   | out_valid/out_stall| status, out_a..c, row_index
//
// Load: each column's walk shifts one entry per cycle per stored row greater
//   than the new row; the result waits for the slowest column.
// Query: order memory read, then row memory read. Others answer from idle.
// One request at a time; the next is taken once the previous result is in the
//   output register and not stalled. Reset empties the table; memories need no
//   clearing pass. Output register holds its result while out_stall is high.
// Top level; instantiates rirl_row_mem and rirl_order_col, uses rirl_pkg.
`default_nettype none

module rank_indexed_row_lookup #(
	parameter int MAX_ROWS = rirl_pkg::MAX_ROWS_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      in_valid,
	output logic                                     in_stall,
	input  wire  [rirl_pkg::CMD_W-1:0]               command,
	input  wire  signed [rirl_pkg::VALUE_W-1:0]      value_a,
	input  wire  signed [rirl_pkg::VALUE_W-1:0]      value_b,
	input  wire  signed [rirl_pkg::VALUE_W-1:0]      value_c,
	input  wire  [rirl_pkg::COL_W-1:0]               column_select,
	input  wire  [rirl_pkg::RANK_W-1:0]              rank,
	output logic                                     out_valid,
	input  wire                                      out_stall,
	output logic [rirl_pkg::STATUS_W-1:0]            status,
	output logic signed [rirl_pkg::VALUE_W-1:0]      out_a,
	output logic signed [rirl_pkg::VALUE_W-1:0]      out_b,
	output logic signed [rirl_pkg::VALUE_W-1:0]      out_c,
	output logic [rirl_pkg::ROW_INDEX_W-1:0]         row_index
);
	import rirl_pkg::*;

	localparam int IDX_W = $clog2(MAX_ROWS);
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_QRD1 = 2'd2;
	localparam logic [1:0] S_QRD2 = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [COL_W-1:0] col_q;
	logic [IDX_W-1:0] idx_q;

	logic                         out_valid_q;
	logic [STATUS_W-1:0]          status_q;
	logic signed [VALUE_W-1:0]    out_a_q;
	logic signed [VALUE_W-1:0]    out_b_q;
	logic signed [VALUE_W-1:0]    out_c_q;
	logic [ROW_INDEX_W-1:0]       row_index_q;

	logic out_free;
	logic in_accept;
	logic full;
	logic bad_col;
	logic rank_ge;

	logic signed [VALUE_W-1:0] col_val [NUM_COLUMNS];
	logic [IDX_W-1:0]          col_idx [NUM_COLUMNS];
	logic [NUM_COLUMNS-1:0]    col_busy;
	logic                      ins_start;
	logic                      qry_en;
	logic [IDX_W-1:0]          qry_addr;
	logic [IDX_W-1:0]          sel_idx;

	logic                      row_wr_en;
	row_t                      row_wr_data;
	logic                      row_rd_en;
	row_t                      row_rd_data;

	logic                      out_load;
	logic [STATUS_W-1:0]       nx_status;
	row_t                      nx_row;
	logic [ROW_INDEX_W-1:0]    nx_row_index;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && out_free);
	assign in_accept = in_valid && !in_stall;

	assign full    = (count_q == CNT_W'(MAX_ROWS));
	assign bad_col = (column_select >= COL_W'(NUM_COLUMNS));
	assign rank_ge = (CMP_W'(rank) >= CMP_W'(count_q));

	assign col_val[0] = value_a;
	assign col_val[1] = value_b;
	assign col_val[2] = value_c;

	assign ins_start   = in_accept && (command == CMD_LOAD) && !full;
	assign row_wr_en   = ins_start;
	assign row_wr_data = '{a: value_a, b: value_b, c: value_c};
	assign qry_en      = in_accept && (command == CMD_QUERY) && !bad_col && !rank_ge;
	assign qry_addr    = IDX_W'(CMP_W'(rank));

	always_comb begin
		unique case (col_q)
			2'd0:    sel_idx = col_idx[0];
			2'd1:    sel_idx = col_idx[1];
			default: sel_idx = col_idx[2];
		endcase
	end

	assign row_rd_en = (state_q == S_QRD1);

	rirl_row_mem #(.MAX_ROWS(MAX_ROWS)) u_row_mem (
		.clk     (clk),
		.wr_en   (row_wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (row_wr_data),
		.rd_en   (row_rd_en),
		.rd_addr (sel_idx),
		.rd_data (row_rd_data)
	);

	for (genvar g = 0; g < NUM_COLUMNS; g++) begin : g_col
		rirl_order_col #(.MAX_ROWS(MAX_ROWS)) u_order (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (ins_start),
			.new_val  (col_val[g]),
			.new_idx  (count_q[IDX_W-1:0]),
			.qry_en   (qry_en),
			.qry_addr (qry_addr),
			.qry_idx  (col_idx[g]),
			.busy     (col_busy[g])
		);
	end

	// result selection
	always_comb begin
		out_load     = 1'b0;
		nx_status    = STAT_OK;
		nx_row       = '0;
		nx_row_index = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					unique case (command)
						CMD_LOAD: begin
							out_load  = full;
							nx_status = STAT_FULL;
						end
						CMD_QUERY: begin
							out_load  = bad_col || rank_ge;
							nx_status = bad_col ? STAT_BADCOL : STAT_RANGE;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_INS: begin
				out_load = (col_busy == '0) && out_free;
			end
			S_QRD2: begin
				out_load     = out_free;
				nx_row       = row_rd_data;
				nx_row_index = ROW_INDEX_W'(idx_q);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (ins_start) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_INS;
						end else if (qry_en) begin
							state_q <= S_QRD1;
						end else if (command == CMD_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				S_INS: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				S_QRD1: begin
					state_q <= S_QRD2;
				end
				default: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (qry_en) begin
			col_q <= column_select;
		end
		if (state_q == S_QRD1) begin
			idx_q <= sel_idx;
		end
		if (out_load) begin
			status_q    <= nx_status;
			out_a_q     <= nx_row.a;
			out_b_q     <= nx_row.b;
			out_c_q     <= nx_row.c;
			row_index_q <= nx_row_index;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_a     = out_a_q;
	assign out_b     = out_b_q;
	assign out_c     = out_c_q;
	assign row_index = row_index_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ROWS))
		else $error("row count above table size");

	a_busy_only_ins: assert property (@(posedge clk) disable iff (!arst_n)
		(col_busy != '0) |-> (state_q == S_INS))
		else $error("insert engine busy outside load");

	a_load_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ins_start |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted load did not bump row count");

	a_query_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QRD2 && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("query result not delivered");

endmodule

`default_nettype wire
